// File: hdl/bwws_pkg.sv
// Shared constants, types and helpers of the bilinear wavetable waveshaper.
package bwws_pkg;

   localparam int ROWS        = 16;
   localparam int COLS        = 256;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int COL_W       = $clog2(COLS);
   localparam int ADDR_W      = 1 + ROW_W + COL_W;
   localparam int TABLE_DEPTH = 2 ** ADDR_W;
   localparam int DATA_W      = 16;
   localparam int FRAC_W      = 16;
   localparam int MORPH_W     = 17;
   localparam int CPOS_W      = FRAC_W + COL_W;
   localparam int RPOS_W      = MORPH_W + ROW_W;
   localparam int PROD_W      = DATA_W + 1 + FRAC_W + 1;
   localparam int TOP_W       = DATA_W + FRAC_W;
   localparam int ACC_W       = TOP_W + 1 + FRAC_W + 1;
   localparam int CMD_DEPTH   = 2;
   localparam int CMD_AW      = $clog2(CMD_DEPTH);
   localparam int CMD_CW      = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_AW      = $clog2(RSP_DEPTH);
   localparam int RSP_CW      = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_SHAPE = 2'd0,
      OP_WRITE = 2'd1,
      OP_SWAP  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RD1,
      BK_RD2,
      BK_RD3
   } back_state_type;

   typedef struct packed {
      logic                     is_write;
      logic                     bank;
      logic [ROW_W-1:0]         row0;
      logic [ROW_W-1:0]         row1;
      logic [COL_W-1:0]         col0;
      logic [COL_W-1:0]         col1;
      logic [FRAC_W-1:0]        row_frac;
      logic [FRAC_W-1:0]        col_frac;
      logic signed [DATA_W-1:0] wdata;
   } cmd_type;

   function automatic logic [ADDR_W-1:0] table_addr(input logic bank,
                                                    input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      return {bank, row, col};
   endfunction

endpackage

// File: hdl/bwws_ram.sv
// Generic single-port RAM with registered read data.
module bwws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

// File: hdl/bwws_front.sv
// Front end: accepts beats, maps positions to table coordinates, queues commands.
module bwws_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_operation,
   input  logic signed [15:0]   req_sample,
   input  logic [16:0]          req_morph,
   input  logic [3:0]           req_row_index,
   input  logic [7:0]           req_col_index,
   input  logic signed [15:0]   req_entry_value,
   output bwws_pkg::cmd_type    cmd,
   output logic                 cmd_valid,
   input  logic                 cmd_pop
);

   bwws_pkg::cmd_type                  queue_ff [bwws_pkg::CMD_DEPTH];
   logic [bwws_pkg::CMD_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [bwws_pkg::CMD_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [bwws_pkg::CMD_CW-1:0]        count_ff, count_in;
   logic                               bank_ff, bank_in;
   logic                               accept;
   logic                               enq;
   bwws_pkg::cmd_type                  entry;
   logic [15:0]                        u_w;
   logic [bwws_pkg::CPOS_W-1:0]        cpos_w;
   logic [bwws_pkg::RPOS_W-1:0]        rpos_w;
   logic [bwws_pkg::MORPH_W-1:0]       m_w;
   logic [bwws_pkg::COL_W:0]           c1_w;
   logic [bwws_pkg::ROW_W:0]           r1_w;
   logic [bwws_pkg::COL_W-1:0]         col0_w;
   logic [bwws_pkg::ROW_W-1:0]         row0_w;

   assign req_full  = (count_ff == bwws_pkg::CMD_CW'(bwws_pkg::CMD_DEPTH));
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      u_w    = {~req_sample[15], req_sample[14:0]};
      cpos_w = bwws_pkg::CPOS_W'(u_w) * bwws_pkg::CPOS_W'(bwws_pkg::COLS - 1);
      col0_w = cpos_w[bwws_pkg::FRAC_W +: bwws_pkg::COL_W];
      c1_w   = {1'b0, col0_w} + 1'b1;
      m_w    = (req_morph > 17'd65536) ? 17'd65536 : req_morph;
      rpos_w = bwws_pkg::RPOS_W'(m_w) * bwws_pkg::RPOS_W'(bwws_pkg::ROWS - 1);
      row0_w = rpos_w[bwws_pkg::FRAC_W +: bwws_pkg::ROW_W];
      r1_w   = {1'b0, row0_w} + 1'b1;

      entry          = '0;
      entry.bank     = bank_ff;
      entry.row0     = row0_w;
      entry.col0     = col0_w;
      entry.row1     = (r1_w < (bwws_pkg::ROW_W + 1)'(bwws_pkg::ROWS - 1)) ?
                       r1_w[bwws_pkg::ROW_W-1:0] : bwws_pkg::ROW_W'(bwws_pkg::ROWS - 1);
      entry.col1     = (c1_w < (bwws_pkg::COL_W + 1)'(bwws_pkg::COLS - 1)) ?
                       c1_w[bwws_pkg::COL_W-1:0] : bwws_pkg::COL_W'(bwws_pkg::COLS - 1);
      entry.row_frac = rpos_w[bwws_pkg::FRAC_W-1:0];
      entry.col_frac = cpos_w[bwws_pkg::FRAC_W-1:0];
      bank_in        = bank_ff;
      enq            = 1'b0;

      if (accept) begin
         case (req_operation)
            bwws_pkg::OP_SHAPE: begin
               enq = 1'b1;
            end
            bwws_pkg::OP_WRITE: begin
               entry.is_write = 1'b1;
               entry.bank     = ~bank_ff;
               entry.row0     = bwws_pkg::ROW_W'(req_row_index);
               entry.col0     = bwws_pkg::COL_W'(req_col_index);
               entry.wdata    = req_entry_value;
               enq = (int'(req_row_index) < bwws_pkg::ROWS) &&
                     (int'(req_col_index) < bwws_pkg::COLS);
            end
            bwws_pkg::OP_SWAP: begin
               bank_in = ~bank_ff;
            end
            default: begin
               enq = 1'b0;
            end
         endcase
      end

      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!enq && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         bank_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         bank_ff   <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: hdl/bwws_back.sv
// Back end: table writes, four-read sequencer and the interpolation pipeline.
module bwws_back (
   input  logic                              clock,
   input  logic                              reset,
   input  bwws_pkg::cmd_type                 cmd,
   input  logic                              cmd_valid,
   output logic                              cmd_pop,
   output logic                              rsp_push,
   output logic signed [bwws_pkg::DATA_W-1:0] rsp_value,
   input  logic                              rsp_taken
);

   bwws_pkg::back_state_type              state_ff, state_in;
   bwws_pkg::back_state_type              rd_tag_ff;
   logic                                  rd_vld_ff;
   logic                                  rd_issue;
   logic                                  start;
   logic                                  ram_we;
   logic [bwws_pkg::ADDR_W-1:0]           ram_addr;
   logic [bwws_pkg::DATA_W-1:0]           ram_rdata;
   logic [bwws_pkg::RSP_CW-1:0]           pending_ff, pending_in;
   logic [bwws_pkg::FRAC_W-1:0]           row_frac_ff, col_frac_ff, col_frac_a_ff;
   logic signed [bwws_pkg::DATA_W-1:0]    v00_ff, v10_ff, v01_ff, v11_w;
   logic                                  a_vld_ff, b_vld_ff;
   logic signed [bwws_pkg::TOP_W-1:0]     top_ff, bot_ff;
   logic signed [bwws_pkg::ACC_W-1:0]     acc_ff;
   logic signed [bwws_pkg::DATA_W:0]      dt_w, db_w;
   logic signed [bwws_pkg::FRAC_W:0]      rt_w, ct_w;
   logic signed [bwws_pkg::PROD_W-1:0]    top_w, bot_w;
   logic signed [bwws_pkg::TOP_W:0]       dd_w;
   logic signed [bwws_pkg::ACC_W-1:0]     acc_w, rnd_w;
   logic signed [bwws_pkg::ACC_W-33:0]    r_w;

   bwws_ram #(
      .WIDTH (bwws_pkg::DATA_W),
      .DEPTH (bwws_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (cmd.wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      ram_we   = 1'b0;
      ram_addr = bwws_pkg::table_addr(cmd.bank, cmd.row0, cmd.col0);
      cmd_pop  = 1'b0;
      rd_issue = 1'b0;
      start    = 1'b0;
      case (state_ff)
         bwws_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.is_write) begin
                  ram_we  = 1'b1;
                  cmd_pop = 1'b1;
               end else if (pending_ff < bwws_pkg::RSP_CW'(bwws_pkg::RSP_DEPTH)) begin
                  rd_issue = 1'b1;
                  start    = 1'b1;
                  state_in = bwws_pkg::BK_RD1;
               end
            end
         end
         bwws_pkg::BK_RD1: begin
            ram_addr = bwws_pkg::table_addr(cmd.bank, cmd.row1, cmd.col0);
            rd_issue = 1'b1;
            state_in = bwws_pkg::BK_RD2;
         end
         bwws_pkg::BK_RD2: begin
            ram_addr = bwws_pkg::table_addr(cmd.bank, cmd.row0, cmd.col1);
            rd_issue = 1'b1;
            state_in = bwws_pkg::BK_RD3;
         end
         bwws_pkg::BK_RD3: begin
            ram_addr = bwws_pkg::table_addr(cmd.bank, cmd.row1, cmd.col1);
            rd_issue = 1'b1;
            cmd_pop  = 1'b1;
            state_in = bwws_pkg::BK_IDLE;
         end
         default: begin
            state_in = bwws_pkg::BK_IDLE;
         end
      endcase

      pending_in = pending_ff;
      if (start && !rsp_taken) begin
         pending_in = pending_ff + 1'b1;
      end else if (!start && rsp_taken) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bwws_pkg::BK_IDLE;
         rd_vld_ff  <= 1'b0;
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         pending_ff <= '0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_issue;
         a_vld_ff   <= rd_vld_ff && (rd_tag_ff == bwws_pkg::BK_RD3);
         b_vld_ff   <= a_vld_ff;
         pending_ff <= pending_in;
      end
   end

   // The upper neighbors blend with the lower ones along the row fraction first.
   always_comb begin
      v11_w = $signed(ram_rdata);
      rt_w  = $signed({1'b0, row_frac_ff});
      dt_w  = (bwws_pkg::DATA_W + 1)'(v10_ff) - (bwws_pkg::DATA_W + 1)'(v00_ff);
      db_w  = (bwws_pkg::DATA_W + 1)'(v11_w) - (bwws_pkg::DATA_W + 1)'(v01_ff);
      top_w = $signed({v00_ff, {bwws_pkg::FRAC_W{1'b0}}}) + dt_w * rt_w;
      bot_w = $signed({v01_ff, {bwws_pkg::FRAC_W{1'b0}}}) + db_w * rt_w;
      ct_w  = $signed({1'b0, col_frac_a_ff});
      dd_w  = (bwws_pkg::TOP_W + 1)'(bot_ff) - (bwws_pkg::TOP_W + 1)'(top_ff);
      acc_w = $signed({top_ff, {bwws_pkg::FRAC_W{1'b0}}}) + dd_w * ct_w;
      rnd_w = acc_ff + $signed({{(bwws_pkg::ACC_W - 32){1'b0}}, 32'h8000_0000});
      r_w   = rnd_w[bwws_pkg::ACC_W-1:32];
      if (r_w > (bwws_pkg::ACC_W - 32)'(32767)) begin
         rsp_value = 16'sh7FFF;
      end else if (r_w < (bwws_pkg::ACC_W - 32)'(-32768)) begin
         rsp_value = 16'sh8000;
      end else begin
         rsp_value = r_w[bwws_pkg::DATA_W-1:0];
      end
   end

   assign rsp_push = b_vld_ff;

   always_ff @(posedge clock) begin
      rd_tag_ff <= state_ff;
      if (state_ff == bwws_pkg::BK_RD3) begin
         row_frac_ff <= cmd.row_frac;
         col_frac_ff <= cmd.col_frac;
      end
      if (rd_vld_ff) begin
         case (rd_tag_ff)
            bwws_pkg::BK_IDLE: v00_ff <= $signed(ram_rdata);
            bwws_pkg::BK_RD1:  v10_ff <= $signed(ram_rdata);
            bwws_pkg::BK_RD2:  v01_ff <= $signed(ram_rdata);
            default: begin
            end
         endcase
      end
      top_ff        <= top_w[bwws_pkg::TOP_W-1:0];
      bot_ff        <= bot_w[bwws_pkg::TOP_W-1:0];
      col_frac_a_ff <= col_frac_ff;
      acc_ff        <= acc_w;
   end

endmodule

// File: hdl/bwws_rsp_queue.sv
// Result queue that holds finished samples until the receiver pops them.
module bwws_rsp_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic signed [bwws_pkg::DATA_W-1:0] push_value,
   input  logic                               pop,
   output logic                               empty,
   output logic signed [bwws_pkg::DATA_W-1:0] head_value
);

   logic signed [bwws_pkg::DATA_W-1:0] queue_ff [bwws_pkg::RSP_DEPTH];
   logic [bwws_pkg::RSP_AW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [bwws_pkg::RSP_CW-1:0]        count_ff, count_in;
   logic                               take;

   assign empty      = (count_ff == '0);
   assign take       = pop && !empty;
   assign head_value = queue_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (!push && take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_value;
      end
   end

endmodule

// File: hdl/bilinear_wavetable_waveshaper.sv
// Top level of the bilinear wavetable waveshaper.
//
// Input channel: a beat is taken when req_push is high and req_full is low.
// A shape beat yields one result; a write beat stores one entry into the
// staging bank through one back-end table write; a swap beat flips the active
// bank at once in the front end and costs no back-end time. Code 3 is dropped.
// Result channel: the oldest result sits on rsp_shaped_sample while
// rsp_empty is low and leaves when rsp_pop is high.
// Path: command queue, four table reads, read data, row blend, column blend,
// result queue. The back end takes no new shape beat until the four reads of
// the single-port table memory are issued; a write needs one table access.
// A two-entry command queue lets the front keep taking beats while the back
// works. When the receiver stalls, the back holds shape commands once four
// results are in flight or waiting, and req_full rises as the queue fills.
// Reset empties both queues and selects bank 0 as active; the table itself
// is not cleared, and entries must be written before they are read.
module bilinear_wavetable_waveshaper (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_operation,
   input  logic signed [15:0]  req_sample,
   input  logic [16:0]         req_morph,
   input  logic [3:0]          req_row_index,
   input  logic [7:0]          req_col_index,
   input  logic signed [15:0]  req_entry_value,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [15:0]  rsp_shaped_sample
);

   bwws_pkg::cmd_type                  cmd;
   logic                               cmd_valid;
   logic                               cmd_pop;
   logic                               rsp_push;
   logic signed [bwws_pkg::DATA_W-1:0] rsp_value;
   logic                               rsp_taken;

   assign rsp_taken = rsp_pop && !rsp_empty;

   bwws_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_sample      (req_sample),
      .req_morph       (req_morph),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_entry_value (req_entry_value),
      .cmd             (cmd),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop)
   );

   bwws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_value (rsp_value),
      .rsp_taken (rsp_taken)
   );

   bwws_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp_push),
      .push_value (rsp_value),
      .pop        (rsp_pop),
      .empty      (rsp_empty),
      .head_value (rsp_shaped_sample)
   );

endmodule

// File: hdl/bwws_checker.sv
// Port-level checks of the waveshaper and the bind that attaches them.
module bwws_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_push,
   input logic                req_full,
   input logic                rsp_empty,
   input logic                rsp_pop,
   input logic signed [15:0]  rsp_shaped_sample
);

   // Reset leaves both queues empty.
   assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // The command queue only fills on an accepted beat.
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push && !req_full))
      else $error("req_full rose without an accepted beat");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result vanished");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_shaped_sample))
      else $error("waiting result changed");

endmodule

bind bilinear_wavetable_waveshaper bwws_checker u_bwws_checker (
   .clock             (clock),
   .reset             (reset),
   .req_push          (req_push),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_shaped_sample (rsp_shaped_sample)
);

// File: verif/tb_top.sv
// Self-checking testbench of the bilinear wavetable waveshaper.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 1350;
   localparam int SHAPE_COLS [8] = '{0, 1, 63, 127, 128, 191, 253, 254};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [1:0] req_operation = bwws_pkg::OP_SHAPE;
   logic signed [15:0] req_sample = '0;
   logic [16:0] req_morph = '0;
   logic [3:0] req_row_index = '0;
   logic [7:0] req_col_index = '0;
   logic signed [15:0] req_entry_value = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [15:0] rsp_shaped_sample;

   logic signed [15:0] wave_table [2][bwws_pkg::ROWS][bwws_pkg::COLS];
   logic live_bank = 1'b0;
   logic signed [15:0] shaped_expected [$];

   int errors = 0;
   int cycles = 0;
   int results_seen = 0;
   int shape_count = 0;
   int write_count = 0;
   int swap_count = 0;
   int dropped_count = 0;
   int burst_left = 0;
   bit tx_steady = 1'b0;

   int rx_mode = 0;
   int rx_timer = 0;
   int stall_left = 0;

   bilinear_wavetable_waveshaper dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_operation(req_operation),
      .req_sample(req_sample),
      .req_morph(req_morph),
      .req_row_index(req_row_index),
      .req_col_index(req_col_index),
      .req_entry_value(req_entry_value),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_shaped_sample(rsp_shaped_sample)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, shaped_expected.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic logic signed [15:0] shape_of(input logic signed [15:0] smp,
                                                   input logic [16:0] mph);
      longint u, cpos, colt, m, rpos, rowt;
      longint v00, v10, v01, v11, top, bot, acc, r;
      int col0, col1, row0, row1;
      u = longint'(smp) + 32768;
      cpos = u * (bwws_pkg::COLS - 1);
      col0 = int'(cpos >> 16);
      colt = cpos & 64'hFFFF;
      col1 = (col0 + 1 < bwws_pkg::COLS - 1) ? col0 + 1 : bwws_pkg::COLS - 1;
      m = (mph > 17'd65536) ? 64'sd65536 : longint'(mph);
      rpos = m * (bwws_pkg::ROWS - 1);
      row0 = int'(rpos >> 16);
      rowt = rpos & 64'hFFFF;
      row1 = (row0 + 1 < bwws_pkg::ROWS - 1) ? row0 + 1 : bwws_pkg::ROWS - 1;
      v00 = longint'(wave_table[live_bank][row0][col0]);
      v10 = longint'(wave_table[live_bank][row1][col0]);
      v01 = longint'(wave_table[live_bank][row0][col1]);
      v11 = longint'(wave_table[live_bank][row1][col1]);
      top = v00 * (65536 - rowt) + v10 * rowt;
      bot = v01 * (65536 - rowt) + v11 * rowt;
      acc = top * (65536 - colt) + bot * colt;
      r = (acc + 64'sd2147483648) >>> 32;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   task automatic send_beat(input logic [1:0] op, input logic signed [15:0] smp,
                            input logic [16:0] mph, input logic [3:0] row,
                            input logic [7:0] col, input logic signed [15:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = tx_steady ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_push <= 1'b1;
      req_operation <= op;
      req_sample <= smp;
      req_morph <= mph;
      req_row_index <= row;
      req_col_index <= col;
      req_entry_value <= val;
      do @(posedge clock); while (req_full);
      case (op)
         bwws_pkg::OP_SHAPE: begin
            shaped_expected.push_back(shape_of(smp, mph));
            shape_count++;
         end
         bwws_pkg::OP_WRITE: begin
            wave_table[~live_bank][row][col] = val;
            write_count++;
         end
         bwws_pkg::OP_SWAP: begin
            live_bank = ~live_bank;
            swap_count++;
         end
         default: dropped_count++;
      endcase
   endtask

   task automatic shape_beat(input logic signed [15:0] smp, input logic [16:0] mph);
      send_beat(bwws_pkg::OP_SHAPE, smp, mph, 4'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic write_beat(input logic [3:0] row, input logic [7:0] col,
                             input logic signed [15:0] val);
      send_beat(bwws_pkg::OP_WRITE, 16'($urandom), 17'($urandom), row, col, val);
   endtask

   task automatic swap_beat();
      send_beat(bwws_pkg::OP_SWAP, 16'($urandom), 17'($urandom), 4'($urandom),
                8'($urandom), 16'($urandom));
   endtask

   task automatic dropped_beat();
      send_beat(OP_UNUSED, 16'($urandom), 17'($urandom), 4'($urandom),
                8'($urandom), 16'($urandom));
   endtask

   function automatic logic signed [15:0] random_entry();
      case ($urandom_range(0, 15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [16:0] random_morph();
      case ($urandom_range(0, 19))
         0: return 17'd0;
         1: return 17'd65536;
         2, 3, 4: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // Picks a sample whose left interpolation column is col.
   function automatic logic signed [15:0] sample_for_col(input int col);
      int u_lo, u_hi;
      u_lo = (col * 65536 + 254) / 255;
      u_hi = ((col + 1) * 65536 + 254) / 255 - 1;
      if (u_hi > 65535) u_hi = 65535;
      return 16'($urandom_range(u_lo, u_hi) - 32768);
   endfunction

   task automatic fill_tables();
      for (int b = 0; b < 2; b++) begin
         for (int r = 0; r < bwws_pkg::ROWS; r++) begin
            for (int k = 0; k < 8; k++) begin
               write_beat(4'(r), 8'(SHAPE_COLS[k]), random_entry());
               write_beat(4'(r), 8'(SHAPE_COLS[k] + 1), random_entry());
            end
         end
         swap_beat();
      end
   endtask

   task automatic test_extremes();
      write_beat(4'd0, 8'd0, 16'sh8000);
      write_beat(4'd0, 8'd1, 16'sh7FFF);
      write_beat(4'(bwws_pkg::ROWS - 1), 8'(bwws_pkg::COLS - 1), 16'sh7FFF);
      write_beat(4'(bwws_pkg::ROWS - 1), 8'(bwws_pkg::COLS - 2), 16'sh8000);
      write_beat(4'd1, 8'd0, 16'sh7FFF);
      swap_beat();
      shape_beat(16'sh8000, 17'd0);
      shape_beat(16'sh7FFF, 17'd65536);
      shape_beat(16'sh7FFF, 17'h1FFFF);
      shape_beat(16'shFFFF, 17'd65535);
      shape_beat(16'sh0000, 17'd1);
      shape_beat(16'sh0000, 17'd65537);
      shape_beat(16'sh8000, 17'd65536);
      shape_beat(16'sh7FFF, 17'd0);
      dropped_beat();
      dropped_beat();
      shape_beat(16'sh4000, 17'd32768);
      swap_beat();
      shape_beat(16'sh8000, 17'd0);
      shape_beat(16'sh7FFF, 17'h10001);
   endtask

   task automatic test_random();
      int pick;
      logic signed [15:0] smp;
      logic [7:0] col;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 300 == 0) tx_steady = $urandom_range(0, 2) == 0;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            case ($urandom_range(0, 15))
               0: smp = 16'sh8000;
               1: smp = 16'sh7FFF;
               default: smp = sample_for_col(SHAPE_COLS[$urandom_range(0, 7)]);
            endcase
            shape_beat(smp, random_morph());
         end else if (pick < 90) begin
            if ($urandom_range(0, 1) == 0) begin
               col = 8'($urandom);
            end else begin
               col = 8'(SHAPE_COLS[$urandom_range(0, 7)] + $urandom_range(0, 1));
            end
            write_beat(4'($urandom), col, random_entry());
         end else if (pick < 95) begin
            swap_beat();
         end else begin
            dropped_beat();
         end
      end
      tx_steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (rx_timer == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_timer <= 255;
      end else begin
         rx_timer <= rx_timer - 1;
      end
      if (stall_left != 0) begin
         rsp_pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         case (rx_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= 1'($urandom_range(0, 1));
            2: begin
               if ($urandom_range(0, 31) == 0) begin
                  stall_left <= $urandom_range(5, 40);
                  rsp_pop <= 1'b0;
               end else begin
                  rsp_pop <= 1'b1;
               end
            end
            default: rsp_pop <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (shaped_expected.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual shaped_sample %0d",
                     $time, rsp_shaped_sample);
            errors++;
         end else if (rsp_shaped_sample !== shaped_expected[0]) begin
            $display("%0t: shaped_sample mismatch, expected %0d, actual %0d",
                     $time, shaped_expected[0], rsp_shaped_sample);
            errors++;
            void'(shaped_expected.pop_front());
         end else begin
            void'(shaped_expected.pop_front());
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fill_tables();
      test_extremes();
      test_random();
      req_push <= 1'b0;
      while (shaped_expected.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Covered %0d shape, %0d write, %0d swap and %0d dropped beats.",
               shape_count, write_count, swap_count, dropped_count);
      $display("Checked %0d results with %0d mismatches.", results_seen, errors);
      if (errors == 0 && shaped_expected.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
